// ===== design/cfp_pkg.sv =====
// Package for the class file stream parser: payload structs, phase, section and
// tag codes, field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cfp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } cfp_in_t;

    typedef struct packed {
        logic [2:0]  section;
        logic [4:0]  field_kind;
        logic [31:0] field_value;
        logic [15:0] item_number;
        logic        done_res;
        logic        error;
    } cfp_out_t;

    localparam logic [5:0] PH_MAGIC     = 6'd0;
    localparam logic [5:0] PH_MINOR     = 6'd1;
    localparam logic [5:0] PH_MAJOR     = 6'd2;
    localparam logic [5:0] PH_POOL_CNT  = 6'd3;
    localparam logic [5:0] PH_TAG       = 6'd4;
    localparam logic [5:0] PH_UTF_LEN   = 6'd5;
    localparam logic [5:0] PH_UTF_BYTE  = 6'd6;
    localparam logic [5:0] PH_INT       = 6'd7;
    localparam logic [5:0] PH_FLOAT     = 6'd8;
    localparam logic [5:0] PH_WIDE_HI   = 6'd9;
    localparam logic [5:0] PH_WIDE_LO   = 6'd10;
    localparam logic [5:0] PH_CLASS_IDX = 6'd11;
    localparam logic [5:0] PH_STR_IDX   = 6'd12;
    localparam logic [5:0] PH_REF_CLS   = 6'd13;
    localparam logic [5:0] PH_REF_NAT   = 6'd14;
    localparam logic [5:0] PH_NAT_NAME  = 6'd15;
    localparam logic [5:0] PH_NAT_DESC  = 6'd16;
    localparam logic [5:0] PH_ACCESS    = 6'd17;
    localparam logic [5:0] PH_THIS      = 6'd18;
    localparam logic [5:0] PH_SUPER     = 6'd19;
    localparam logic [5:0] PH_IF_CNT    = 6'd20;
    localparam logic [5:0] PH_IF        = 6'd21;
    localparam logic [5:0] PH_FLD_CNT   = 6'd22;
    localparam logic [5:0] PH_MEM_ACC   = 6'd23;
    localparam logic [5:0] PH_MEM_NAME  = 6'd24;
    localparam logic [5:0] PH_MEM_DESC  = 6'd25;
    localparam logic [5:0] PH_MEM_ACNT  = 6'd26;
    localparam logic [5:0] PH_MTH_CNT   = 6'd27;
    localparam logic [5:0] PH_ATTR_NAME = 6'd28;
    localparam logic [5:0] PH_ATTR_LEN  = 6'd29;
    localparam logic [5:0] PH_ATTR_BYTE = 6'd30;
    localparam logic [5:0] PH_CATTR_CNT = 6'd31;
    localparam logic [5:0] PH_STOP      = 6'd32;

    localparam logic [2:0] SEC_POOL   = 3'd0;
    localparam logic [2:0] SEC_CLASS  = 3'd1;
    localparam logic [2:0] SEC_FIELD  = 3'd2;
    localparam logic [2:0] SEC_METHOD = 3'd3;
    localparam logic [2:0] SEC_CATTR  = 3'd4;

    localparam logic [3:0] TAG_UTF8   = 4'd1;
    localparam logic [3:0] TAG_INT    = 4'd3;
    localparam logic [3:0] TAG_FLOAT  = 4'd4;
    localparam logic [3:0] TAG_LONG   = 4'd5;
    localparam logic [3:0] TAG_DOUBLE = 4'd6;
    localparam logic [3:0] TAG_CLASS  = 4'd7;
    localparam logic [3:0] TAG_STRING = 4'd8;
    localparam logic [3:0] TAG_FREF   = 4'd9;
    localparam logic [3:0] TAG_MREF   = 4'd10;
    localparam logic [3:0] TAG_IREF   = 4'd11;
    localparam logic [3:0] TAG_NAT    = 4'd12;

    // bytes per field, by field kind
    function automatic logic [2:0] field_width(input logic [4:0] kind);
        case (kind)
            5'd0, 5'd7, 5'd8, 5'd9, 5'd10, 5'd29: field_width = 3'd4;
            5'd4, 5'd6, 5'd30:                    field_width = 3'd1;
            default:                              field_width = 3'd2;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== design/cfp_walker.sv =====
// Byte walker of the class file parser: all parse state and the next-state
// logic for one byte. Depends on cfp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cfp_walker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire cfp_pkg::cfp_in_t in_item,
    output logic                  res_valid,
    output cfp_pkg::cfp_out_t     res_item
);
    import cfp_pkg::*;

    logic [5:0]  phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] pool_reg, pool_next;
    logic [15:0] idx_reg, idx_next;
    logic [15:0] mem_reg, mem_next;
    logic [15:0] attr_reg, attr_next;
    logic [31:0] run_reg, run_next;
    logic [3:0]  tag_reg, tag_next;
    logic [2:0]  sec_reg, sec_next;
    logic [1:0]  stop_reg, stop_next;

    always_comb
    begin
        logic [5:0]  ph;
        logic [2:0]  cn;
        logic [31:0] ac;
        logic [31:0] v;
        logic [4:0]  kind;
        logic [15:0] pr, ix, mr, ar, slots;
        logic [31:0] rr;
        logic [3:0]  tg;
        logic [2:0]  sc;
        logic [1:0]  sf;
        logic        cdone, adone, nattr, nmem;

        ph = phase_reg; cn = cnt_reg; ac = acc_reg; pr = pool_reg; ix = idx_reg;
        mr = mem_reg; ar = attr_reg; rr = run_reg; tg = tag_reg; sc = sec_reg;
        sf = stop_reg;
        if (in_item.first_byte)
        begin
            ph = PH_MAGIC; cn = '0; ac = '0; pr = '0; ix = '0; mr = '0; ar = '0;
            rr = '0; tg = '0; sc = SEC_POOL; sf = '0;
        end
        res_valid = 1'b0;
        res_item  = '0;
        cdone = 1'b0; adone = 1'b0; nattr = 1'b0; nmem = 1'b0;
        slots = 16'd1;
        kind = ph[4:0];
        v = '0;
        if (!ph[5] && sf == 2'b00)
        begin
            ac = {ac[23:0], in_item.data_byte};
            cn = cn + 3'd1;
            if (cn >= field_width(kind))
            begin
                v = ac;
                ac = '0;
                cn = '0;
                res_valid = 1'b1;
                res_item.section = sc;
                res_item.field_kind = kind;
                res_item.field_value = v;
                if ((kind >= 5'd4 && kind <= 5'd16) || kind == 5'd21 ||
                    (kind >= 5'd23 && kind <= 5'd26) || (kind >= 5'd28 && kind <= 5'd30))
                    res_item.item_number = ix;
                case (ph)
                    PH_MAGIC, PH_MINOR, PH_MAJOR, PH_ACCESS, PH_THIS, PH_SUPER,
                    PH_MEM_ACC, PH_MEM_NAME, PH_MEM_DESC, PH_WIDE_HI, PH_REF_CLS,
                    PH_NAT_NAME, PH_ATTR_NAME:
                        ph = ph + 6'd1;
                    PH_POOL_CNT:
                    begin
                        pr = (v[15:0] != 16'd0) ? v[15:0] - 16'd1 : 16'd0;
                        ix = 16'd1;
                        if (pr == 16'd0) begin sc = SEC_CLASS; ph = PH_ACCESS; end
                        else ph = PH_TAG;
                    end
                    PH_TAG:
                    begin
                        tg = v[3:0];
                        // tags above 15 must not alias onto a known low tag
                        if (v[31:4] != 28'd0) tg = 4'd0;
                        case (tg)
                            TAG_UTF8:            ph = PH_UTF_LEN;
                            TAG_INT:             ph = PH_INT;
                            TAG_FLOAT:           ph = PH_FLOAT;
                            TAG_LONG, TAG_DOUBLE: ph = PH_WIDE_HI;
                            TAG_CLASS:           ph = PH_CLASS_IDX;
                            TAG_STRING:          ph = PH_STR_IDX;
                            TAG_FREF, TAG_MREF, TAG_IREF: ph = PH_REF_CLS;
                            TAG_NAT:             ph = PH_NAT_NAME;
                            default:
                            begin
                                tg = 4'd0; sf[1] = 1'b1; ph = PH_STOP;
                            end
                        endcase
                    end
                    PH_UTF_LEN:
                    begin
                        rr = v;
                        if (v == 32'd0) cdone = 1'b1; else ph = PH_UTF_BYTE;
                    end
                    PH_UTF_BYTE:
                    begin
                        rr = rr - 32'd1;
                        if (rr == 32'd0) cdone = 1'b1;
                    end
                    PH_INT, PH_FLOAT, PH_WIDE_LO, PH_CLASS_IDX, PH_STR_IDX,
                    PH_REF_NAT, PH_NAT_DESC:
                        cdone = 1'b1;
                    PH_IF_CNT:
                    begin
                        mr = v[15:0]; ix = '0;
                        if (mr == 16'd0) begin sc = SEC_FIELD; ph = PH_FLD_CNT; end
                        else ph = PH_IF;
                    end
                    PH_IF:
                    begin
                        ix = ix + 16'd1; mr = mr - 16'd1;
                        if (mr == 16'd0) begin sc = SEC_FIELD; ph = PH_FLD_CNT; end
                    end
                    PH_FLD_CNT, PH_MTH_CNT:
                    begin
                        mr = v[15:0]; ix = '0; nmem = 1'b1;
                    end
                    PH_MEM_ACNT:
                    begin
                        ar = v[15:0]; nattr = 1'b1;
                    end
                    PH_ATTR_LEN:
                    begin
                        rr = v;
                        if (v == 32'd0) adone = 1'b1; else ph = PH_ATTR_BYTE;
                    end
                    PH_ATTR_BYTE:
                    begin
                        rr = rr - 32'd1;
                        if (rr == 32'd0) adone = 1'b1;
                    end
                    default:
                    begin
                        ar = v[15:0]; ix = '0; nattr = 1'b1;
                    end
                endcase
                if (cdone)
                begin
                    if (tg == TAG_LONG || tg == TAG_DOUBLE) slots = 16'd2;
                    pr = (pr > slots) ? pr - slots : 16'd0;
                    ix = ix + slots;
                    if (pr == 16'd0) begin sc = SEC_CLASS; ph = PH_ACCESS; end
                    else ph = PH_TAG;
                end
                if (adone)
                begin
                    ar = ar - 16'd1;
                    if (sc == SEC_CATTR) ix = ix + 16'd1;
                    nattr = 1'b1;
                end
                if (nattr)
                begin
                    if (ar != 16'd0) ph = PH_ATTR_NAME;
                    else if (sc == SEC_CATTR) begin sf[0] = 1'b1; ph = PH_STOP; end
                    else begin ix = ix + 16'd1; mr = mr - 16'd1; nmem = 1'b1; end
                end
                if (nmem)
                begin
                    if (mr != 16'd0) ph = PH_MEM_ACC;
                    else if (sc == SEC_FIELD) begin sc = SEC_METHOD; ph = PH_MTH_CNT; end
                    else begin sc = SEC_CATTR; ph = PH_CATTR_CNT; end
                end
                res_item.done_res = sf[0];
                res_item.error = sf[1];
            end
        end
        phase_next = ph; cnt_next = cn; acc_next = ac; pool_next = pr; idx_next = ix;
        mem_next = mr; attr_next = ar; run_next = rr; tag_next = tg; sec_next = sc;
        stop_next = sf;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC; cnt_reg <= '0; acc_reg <= '0; pool_reg <= '0;
            idx_reg <= '0; mem_reg <= '0; attr_reg <= '0; run_reg <= '0;
            tag_reg <= '0; sec_reg <= SEC_POOL; stop_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next; cnt_reg <= cnt_next; acc_reg <= acc_next;
            pool_reg <= pool_next; idx_reg <= idx_next; mem_reg <= mem_next;
            attr_reg <= attr_next; run_reg <= run_next; tag_reg <= tag_next;
            sec_reg <= sec_next; stop_reg <= stop_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/class_file_stream_parser.sv =====
// Top level of the class file stream parser: input register, walker, and
// output register with skid stage. Depends on cfp_pkg and cfp_walker.
//
//  channel | direction | handshake          | payload
//  in      | into      | in_valid/in_stall  | cfp_in_t  (data_byte, first_byte)
//  out     | out of    | out_valid/out_stall| cfp_out_t (section .. error)
//
// One byte per cycle, sustained while the skid register is empty. A result is
// offered for each completed field, from the input register through the walker
// step into the output register; that single walker step sets the rate.
// rst_n clears all parse state to "expect magic" and empties the input, output and skid registers.
// An out stall fills the skid register; in_stall rises only when it is full.
`timescale 1ns / 1ps
`default_nettype none
module class_file_stream_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire cfp_pkg::cfp_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output cfp_pkg::cfp_out_t     out_data
);
    import cfp_pkg::*;

    // input register
    logic     inr_valid_reg;
    cfp_in_t  inr_data_reg;
    // output and skid registers
    logic     out_valid_reg, skid_valid_reg;
    cfp_out_t out_data_reg, skid_data_reg;

    logic     res_valid;
    cfp_out_t res_item;
    logic     advance;

    // the walker steps whenever the input register holds a byte and the skid register is empty
    assign advance  = inr_valid_reg && !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    cfp_walker u_walker (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .in_item  (inr_data_reg),
        .res_valid(res_valid),
        .res_item (res_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inr_valid_reg  <= 1'b0;
            inr_data_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            skid_valid_reg <= 1'b0;
            skid_data_reg  <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                inr_valid_reg <= in_valid;
                inr_data_reg  <= in_data;
            end
            else if (advance)
                inr_valid_reg <= 1'b0;
            // output side: drain skid first
            if (!out_valid_reg || !out_stall)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= advance && res_valid;
                    out_data_reg  <= res_item;
                end
            end
            else if (advance && res_valid)
            begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res_item;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a transaction while output is empty");
    a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !advance)
        else $error("walker stepped with skid full");
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> !skid_valid_reg)
        else $error("skid did not drain");
`endif

endmodule
`default_nettype wire
